### design/rcpa_pkg.sv
// shared types and constants of the radio control packet parser
package rcpa_pkg;

  localparam int NUM_VALUES = 5;
  localparam int NUM_STICKS = 3;

  localparam logic [7:0] ACK_TYPE = 8'd100;

  localparam logic [7:0] ASC_0     = 8'h30;
  localparam logic [7:0] ASC_9     = 8'h39;
  localparam logic [7:0] ASC_PLUS  = 8'h2B;
  localparam logic [7:0] ASC_MINUS = 8'h2D;
  localparam logic [7:0] ASC_E     = 8'h45;
  localparam logic [7:0] ASC_R     = 8'h52;
  localparam logic [7:0] ASC_S     = 8'h53;
  localparam logic [7:0] ASC_L     = 8'h4C;
  localparam logic [7:0] ASC_Q     = 8'h51;

  localparam logic [2:0] FI_LEAD = 3'd0;
  localparam logic [2:0] FI_AIL  = 3'd1;
  localparam logic [2:0] FI_ELE  = 3'd2;
  localparam logic [2:0] FI_RUD  = 3'd3;
  localparam logic [2:0] FI_SHA  = 3'd4;
  localparam logic [2:0] FI_SHB  = 3'd5;
  localparam logic [2:0] FI_DONE = 3'd6;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_ACK_LIM  = 1'b1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_kind_t;

  typedef enum logic [3:0] {
    CH_OTHER = 4'd0,
    CH_DIGIT = 4'd1,
    CH_PLUS  = 4'd2,
    CH_MINUS = 4'd3,
    CH_E     = 4'd4,
    CH_R     = 4'd5,
    CH_S     = 4'd6,
    CH_L     = 4'd7,
    CH_Q     = 4'd8
  } char_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_RX   = 2'd1,
    ACT_TX   = 2'd2
  } radio_act_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              is_ack;
    logic signed [8:0] rssi;
    char_t             ch;
    logic [3:0]        digit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### design/rcpa_front.sv
// front end: input handshake and byte classification
module rcpa_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_msg_type,
  input  logic [7:0]         in_rx_byte,
  input  logic signed [8:0]  in_rssi,
  input  rcpa_pkg::q_status_t q_status,
  output logic               q_push,
  output rcpa_pkg::cmd_t     q_cmd
);
  import rcpa_pkg::*;

  logic [7:0] sub_byte;

  assign in_ready = !q_status.full;
  assign q_push   = in_valid && in_ready;
  assign sub_byte = in_rx_byte - ASC_0;

  always_comb begin
    q_cmd        = '0;
    q_cmd.is_ack = (in_msg_type == ACK_TYPE);
    q_cmd.rssi   = in_rssi;
    q_cmd.digit  = sub_byte[3:0];
    unique case (in_op)
      OP_START: q_cmd.kind = CMD_START;
      OP_BYTE:  q_cmd.kind = CMD_BYTE;
      OP_TICK:  q_cmd.kind = CMD_TICK;
      default:  q_cmd.kind = CMD_NOP;
    endcase
    priority if (in_rx_byte >= ASC_0 && in_rx_byte <= ASC_9) begin
      q_cmd.ch = CH_DIGIT;
    end else if (in_rx_byte == ASC_PLUS) begin
      q_cmd.ch = CH_PLUS;
    end else if (in_rx_byte == ASC_MINUS) begin
      q_cmd.ch = CH_MINUS;
    end else if (in_rx_byte == ASC_E) begin
      q_cmd.ch = CH_E;
    end else if (in_rx_byte == ASC_R) begin
      q_cmd.ch = CH_R;
    end else if (in_rx_byte == ASC_S) begin
      q_cmd.ch = CH_S;
    end else if (in_rx_byte == ASC_L) begin
      q_cmd.ch = CH_L;
    end else if (in_rx_byte == ASC_Q) begin
      q_cmd.ch = CH_Q;
    end else begin
      q_cmd.ch = CH_OTHER;
    end
  end

endmodule

### design/rcpa_queue.sv
// short command queue between front end and back end
module rcpa_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rcpa_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output logic                pop_valid,
  output rcpa_pkg::cmd_t      pop_cmd,
  output rcpa_pkg::q_status_t status
);
  import rcpa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_valid    = !status.empty;
  assign pop_cmd      = slot_r[rd_ptr_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### design/rcpa_back.sv
// back end: packet parsing, commit, ack scheduling and result register
module rcpa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        interval_ms,
  input  logic [15:0]        ack_packet_limit,
  input  logic               q_valid,
  input  rcpa_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_aileron,
  output logic signed [15:0] out_elevator,
  output logic signed [15:0] out_rudder,
  output logic [7:0]         out_shoulder_a,
  output logic [7:0]         out_shoulder_b,
  output logic [15:0]        out_packet_total,
  output logic               out_ack_active,
  output logic [1:0]         out_radio_action,
  output logic signed [8:0]  out_telemetry_rssi
);
  import rcpa_pkg::*;

  localparam int IDX_W = $clog2(NUM_VALUES);

  logic [15:0]       cmt_r [NUM_VALUES];
  logic [15:0]       cmt_nxt [NUM_VALUES];
  logic [15:0]       pend_r [NUM_VALUES];
  logic [15:0]       pend_nxt [NUM_VALUES];
  logic [2:0]        fi_r, fi_nxt;
  logic              tag_s_r, tag_s_nxt;
  logic [15:0]       mag_r, mag_nxt;
  logic              started_r, started_nxt;
  logic              neg_r, neg_nxt;
  logic              ended_r, ended_nxt;
  logic              is_data_r, is_data_nxt;
  logic [15:0]       pkt_cnt_r, pkt_cnt_nxt;
  logic              ack_r, ack_nxt;
  logic signed [8:0] rssi_r, rssi_nxt;
  logic [15:0]       elapsed_r, elapsed_nxt;
  logic              out_valid_r, out_valid_nxt;
  radio_act_t        act_r, act_nxt;
  logic signed [8:0] tel_r, tel_nxt;

  logic [2:0]        fin_idx;
  logic [15:0]       fin_val;
  logic [19:0]       mac;
  logic [15:0]       mag_dig;
  logic              s_hit, tag_hit, finish;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  assign fin_idx = fi_r - 3'd1;
  assign mac     = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {16'd0, q_cmd.digit};
  assign mag_dig = (|mac[19:16]) ? 16'hFFFF : mac[15:0];

  always_comb begin
    if (fin_idx < 3'(NUM_STICKS)) begin
      if (neg_r) begin
        fin_val = (mag_r > 16'd32768) ? 16'h8000 : 16'd0 - mag_r;
      end else begin
        fin_val = (mag_r > 16'd32767) ? 16'h7FFF : mag_r;
      end
    end else begin
      if (neg_r) begin
        fin_val = 16'd0;
      end else begin
        fin_val = (mag_r > 16'd255) ? 16'd255 : mag_r;
      end
    end
  end

  assign s_hit   = tag_s_r && ((fi_r == FI_RUD && q_cmd.ch == CH_R) ||
                               (fi_r == FI_SHA && q_cmd.ch == CH_L));
  assign tag_hit = (fi_r == FI_AIL && q_cmd.ch == CH_E) ||
                   (fi_r == FI_ELE && q_cmd.ch == CH_R);
  assign finish  = s_hit || tag_hit || (fi_r == FI_SHB && q_cmd.ch == CH_Q);

  always_comb begin
    cmt_nxt       = cmt_r;
    pend_nxt      = pend_r;
    fi_nxt        = fi_r;
    tag_s_nxt     = tag_s_r;
    mag_nxt       = mag_r;
    started_nxt   = started_r;
    neg_nxt       = neg_r;
    ended_nxt     = ended_r;
    is_data_nxt   = is_data_r;
    pkt_cnt_nxt   = pkt_cnt_r;
    ack_nxt       = ack_r;
    rssi_nxt      = rssi_r;
    elapsed_nxt   = elapsed_r;
    act_nxt       = act_r;
    tel_nxt       = tel_r;
    out_valid_nxt = q_pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

    if (q_pop) begin
      act_nxt = ACT_NONE;
      tel_nxt = '0;
      unique case (q_cmd.kind)
        CMD_START: begin
          rssi_nxt    = q_cmd.rssi;
          fi_nxt      = FI_LEAD;
          tag_s_nxt   = 1'b0;
          mag_nxt     = '0;
          started_nxt = 1'b0;
          neg_nxt     = 1'b0;
          ended_nxt   = 1'b0;
          is_data_nxt = !q_cmd.is_ack;
          if (q_cmd.is_ack) begin
            ack_nxt     = 1'b1;
            pkt_cnt_nxt = '0;
          end
        end
        CMD_BYTE: begin
          if (is_data_r && fi_r < FI_DONE) begin
            if (fi_r == FI_LEAD) begin
              fi_nxt      = FI_AIL;
              mag_nxt     = '0;
              started_nxt = 1'b0;
              neg_nxt     = 1'b0;
              ended_nxt   = 1'b0;
            end else begin
              tag_s_nxt = 1'b0;
              if (finish) begin
                pend_nxt[fin_idx[IDX_W-1:0]] = fin_val;
                mag_nxt     = '0;
                started_nxt = 1'b0;
                neg_nxt     = 1'b0;
                ended_nxt   = 1'b0;
                fi_nxt      = fi_r + 3'd1;
                if (fi_r == FI_SHB) begin
                  cmt_nxt     = pend_nxt;
                  pkt_cnt_nxt = pkt_cnt_r + 16'd1;
                end
              end else if ((fi_r == FI_RUD || fi_r == FI_SHA) && q_cmd.ch == CH_S) begin
                tag_s_nxt = 1'b1;
                ended_nxt = 1'b1;
              end else if (!ended_r) begin
                if (q_cmd.ch == CH_DIGIT) begin
                  mag_nxt     = mag_dig;
                  started_nxt = 1'b1;
                end else if ((q_cmd.ch == CH_PLUS || q_cmd.ch == CH_MINUS) && !started_r) begin
                  mag_nxt     = '0;
                  started_nxt = 1'b1;
                  neg_nxt     = (q_cmd.ch == CH_MINUS);
                end else begin
                  ended_nxt = 1'b1;
                end
              end
            end
          end
        end
        CMD_TICK: begin
          if (elapsed_r != 16'hFFFF) begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
          if (elapsed_nxt > interval_ms) begin
            if (!ack_r || pkt_cnt_r > ack_packet_limit) begin
              ack_nxt = 1'b0;
              act_nxt = ACT_RX;
            end else begin
              act_nxt     = ACT_TX;
              tel_nxt     = rssi_r;
              pkt_cnt_nxt = pkt_cnt_r + 16'd1;
            end
            elapsed_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VALUES; i++) begin
        cmt_r[i]  <= '0;
        pend_r[i] <= '0;
      end
      fi_r        <= FI_LEAD;
      tag_s_r     <= 1'b0;
      mag_r       <= '0;
      started_r   <= 1'b0;
      neg_r       <= 1'b0;
      ended_r     <= 1'b0;
      is_data_r   <= 1'b0;
      pkt_cnt_r   <= '0;
      ack_r       <= 1'b0;
      rssi_r      <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
      act_r       <= ACT_NONE;
      tel_r       <= '0;
    end else begin
      cmt_r       <= cmt_nxt;
      pend_r      <= pend_nxt;
      fi_r        <= fi_nxt;
      tag_s_r     <= tag_s_nxt;
      mag_r       <= mag_nxt;
      started_r   <= started_nxt;
      neg_r       <= neg_nxt;
      ended_r     <= ended_nxt;
      is_data_r   <= is_data_nxt;
      pkt_cnt_r   <= pkt_cnt_nxt;
      ack_r       <= ack_nxt;
      rssi_r      <= rssi_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
      act_r       <= act_nxt;
      tel_r       <= tel_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_aileron        = cmt_r[0];
  assign out_elevator       = cmt_r[1];
  assign out_rudder         = cmt_r[2];
  assign out_shoulder_a     = cmt_r[3][7:0];
  assign out_shoulder_b     = cmt_r[4][7:0];
  assign out_packet_total   = pkt_cnt_r;
  assign out_ack_active     = ack_r;
  assign out_radio_action   = act_r;
  assign out_telemetry_rssi = tel_r;

endmodule

### design/radio_control_packet_parser_ack_core.sv
// top level of the radio control packet parser with ack scheduling
//
//   channel   direction  handshake              transaction
//   in_*      in         in_valid / in_ready    op, msg_type, rx_byte, rssi
//   out_*     out        out_valid / out_ready  sticks, buttons, count, ack, action
//   apb       in         psel/penable/pready    interval_ms, ack_packet_limit
//
// one transaction per cycle unless out_ready stalls; input is queued, then registered as result
// the front end classifies bytes into a command queue, the back end updates state on each pop
// rst_n is synchronous and clears all state but queue contents; registers return to 100 and 5
// a stalled result holds; the queue absorbs QUEUE_DEPTH transactions, then in_ready drops
module radio_control_packet_parser_ack_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_msg_type,
  input  logic [7:0]         in_rx_byte,
  input  logic signed [8:0]  in_rssi,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_aileron,
  output logic signed [15:0] out_elevator,
  output logic signed [15:0] out_rudder,
  output logic [7:0]         out_shoulder_a,
  output logic [7:0]         out_shoulder_b,
  output logic [15:0]        out_packet_total,
  output logic               out_ack_active,
  output logic [1:0]         out_radio_action,
  output logic signed [8:0]  out_telemetry_rssi,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rcpa_pkg::*;

  logic [15:0] interval_r, interval_nxt;
  logic [15:0] ack_lim_r, ack_lim_nxt;
  logic        cfg_wr;
  logic        push, pop, pop_valid;
  cmd_t        push_cmd, pop_cmd;
  q_status_t   q_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    interval_nxt = interval_r;
    ack_lim_nxt  = ack_lim_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_INTERVAL: interval_nxt = pwdata[15:0];
        REG_ACK_LIM:  ack_lim_nxt  = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INTERVAL: prdata = {16'd0, interval_r};
      REG_ACK_LIM:  prdata = {16'd0, ack_lim_r};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 16'd100;
      ack_lim_r  <= 16'd5;
    end else begin
      interval_r <= interval_nxt;
      ack_lim_r  <= ack_lim_nxt;
    end
  end

  rcpa_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_msg_type (in_msg_type),
    .in_rx_byte  (in_rx_byte),
    .in_rssi     (in_rssi),
    .q_status    (q_status),
    .q_push      (push),
    .q_cmd       (push_cmd)
  );

  rcpa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .status    (q_status)
  );

  rcpa_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .interval_ms        (interval_r),
    .ack_packet_limit   (ack_lim_r),
    .q_valid            (pop_valid),
    .q_cmd              (pop_cmd),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_aileron        (out_aileron),
    .out_elevator       (out_elevator),
    .out_rudder         (out_rudder),
    .out_shoulder_a     (out_shoulder_a),
    .out_shoulder_b     (out_shoulder_b),
    .out_packet_total   (out_packet_total),
    .out_ack_active     (out_ack_active),
    .out_radio_action   (out_radio_action),
    .out_telemetry_rssi (out_telemetry_rssi)
  );

`ifndef NO_ASSERTIONS
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !in_ready)
    else $error("input accepted while command queue full");

  a_ack_ends_on_rx: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_ack_active) |-> (out_radio_action == ACT_RX))
    else $error("ack mode ended without receive command");

  a_tx_needs_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_radio_action == ACT_TX) |-> out_ack_active)
    else $error("telemetry transmit outside ack mode");

  a_tel_only_on_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_telemetry_rssi != 9'sd0) |-> (out_radio_action == ACT_TX))
    else $error("telemetry rssi without transmit");
`endif

endmodule
